// ===== sv/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// Holds the request and result beat structs, status and register codes, the
// controller state type and the command and status structs between the modules.
package bsa_pkg;

  localparam int IndexW = 10;
  localparam int CountW = 11;
  localparam int WordsW = 5;
  localparam int CfgDataW = 11;
  localparam int CfgIndexW = 2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  localparam logic [CfgIndexW-1:0] REG_SLOT_CAPACITY = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_WORDS_IN_USE = 2'd1;

  localparam logic [CountW-1:0] CapacityReset = 11'd1024;
  localparam logic [WordsW-1:0] WordsReset = 5'd16;

  typedef struct packed {
    logic              mode;
    logic [IndexW-1:0] free_index;
  } bsa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IndexW-1:0] slot_index;
  } bsa_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FDIV,
    S_FRD,
    S_ACHK,
    S_SCAN
  } bsa_state_t;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       rd_en;
    logic       rd_ahead;
    logic       scan_adv;
    logic       wr_set;
    logic       wr_clr;
    logic       cnt_dec;
    logic       emit;
    logic [1:0] emit_status;
  } bsa_cmd_t;

  typedef struct packed {
    logic mode_free;
    logic rem_ge;
    logic word_in_range;
    logic at_cap;
    logic limit_zero;
    logic data_nonzero;
    logic scan_last;
  } bsa_stat_t;

endpackage

// ===== sv/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: joins the controller and the datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_dpath.
//
//   Channel   Handshake        Payload
//   request   start, busy      req (bsa_req_t: mode, free_index)
//   result    done             rsp (bsa_rsp_t: status, slot_index)
//   config    cfg_we           cfg_index, cfg_data
//
// A request is taken when start is high and busy is low; its result beat
// follows as a one-cycle done strobe. An allocation checks the capacity and the
// word limit, then scans the bitmap word by word; the bitmap memory gives one word a cycle.
// A free subtracts WORD_BITS from the index until it is below WORD_BITS, then reads
// that word and sets its bit; an index beyond the bitmap is not read. The receiver cannot stall.
// Synchronous reset marks every bitmap word free through its valid bit at once.
module bitmap_slot_allocator #(
  parameter int MAP_WORDS = 16,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bsa_pkg::bsa_req_t             req,
  output logic                          done,
  output bsa_pkg::bsa_rsp_t             rsp,
  input  logic                          cfg_we,
  input  logic [bsa_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [bsa_pkg::CfgDataW-1:0]  cfg_data
);
  import bsa_pkg::*;

  bsa_cmd_t  cmd;
  bsa_stat_t stat;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  bsa_dpath #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .rsp       (rsp)
  );

endmodule

// ===== sv/bsa_ctrl.sv =====
// Controller state machine of the bitmap slot allocator.
// Depends on bsa_pkg; drives the datapath through bsa_cmd_t and reads bsa_stat_t.
module bsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output bsa_pkg::bsa_cmd_t cmd,
  input  bsa_pkg::bsa_stat_t stat
);
  import bsa_pkg::*;

  bsa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit_status = STATUS_OK;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_FDIV;
        end
      end
      S_FDIV: begin
        // The first cycle after a load also routes allocations onward.
        if (!stat.mode_free) begin
          state_next = S_ACHK;
        end else if (stat.rem_ge) begin
          cmd.div_step = 1'b1;
        end else if (stat.word_in_range) begin
          cmd.rd_en = 1'b1;
          state_next = S_FRD;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FRD: begin
        cmd.wr_set = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      S_ACHK: begin
        if (stat.at_cap) begin
          cmd.emit = 1'b1;
          cmd.emit_status = STATUS_FULL;
          state_next = S_IDLE;
        end else if (stat.limit_zero) begin
          cmd.emit = 1'b1;
          cmd.emit_status = STATUS_EXHAUSTED;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.data_nonzero) begin
          cmd.wr_clr = 1'b1;
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end else if (stat.scan_last) begin
          cmd.emit = 1'b1;
          cmd.emit_status = STATUS_EXHAUSTED;
          state_next = S_IDLE;
        end else begin
          cmd.scan_adv = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_ahead = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/bsa_dpath.sv =====
// Datapath of the bitmap slot allocator: bitmap memory with per-word valid
// bits, counters, configuration registers and the result register. Depends on bsa_pkg.
module bsa_dpath #(
  parameter int MAP_WORDS = 16,
  parameter int WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bsa_pkg::bsa_req_t               req,
  input  logic                            cfg_we,
  input  logic [bsa_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [bsa_pkg::CfgDataW-1:0]    cfg_data,
  input  bsa_pkg::bsa_cmd_t               cmd,
  output bsa_pkg::bsa_stat_t              stat,
  output logic                            done,
  output bsa_pkg::bsa_rsp_t               rsp
);
  import bsa_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int QMAX = 1023 / WORD_BITS;
  localparam int CMAX = (QMAX > MAP_WORDS) ? QMAX : MAP_WORDS;
  localparam int CW = $clog2(CMAX + 1);
  localparam logic [IndexW-1:0] WordStep = IndexW'(WORD_BITS);
  localparam logic [CW:0] MapWordsW = (CW + 1)'(MAP_WORDS);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_ok;

  logic                 mode;
  logic [IndexW-1:0]    rem;
  logic [CW-1:0]        word;
  logic [IndexW-1:0]    base;
  logic [CountW-1:0]    used_count;
  logic [CountW-1:0]    slot_capacity;
  logic [WordsW-1:0]    words_in_use;

  logic [WORD_BITS-1:0] word_eff;
  logic [BW-1:0]        lsb;
  logic [CW-1:0]        raddr;
  logic [CW:0]          limit;
  logic [CW:0]          word_inc;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wdata;

  always_comb begin
    lsb = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word_eff[i]) begin
        lsb = BW'(i);
      end
    end
  end

  assign word_eff = rd_ok ? rd_data : '1;
  assign raddr = cmd.rd_ahead ? (word + CW'(1)) : word;
  assign word_inc = {1'b0, word} + (CW + 1)'(1);
  assign limit = ((CW + 1)'(words_in_use) > MapWordsW) ? MapWordsW
               : (CW + 1)'(words_in_use);
  assign wr_en = cmd.wr_set | cmd.wr_clr;
  assign wdata = cmd.wr_set ? (word_eff | (WORD_BITS'(1) << rem[BW-1:0]))
               : (word_eff & ~(WORD_BITS'(1) << lsb));

  assign stat.mode_free = (mode == MODE_FREE);
  assign stat.rem_ge = (rem >= WordStep);
  assign stat.word_in_range = ({1'b0, word} < MapWordsW);
  assign stat.at_cap = (used_count >= slot_capacity);
  assign stat.limit_zero = (words_in_use == '0);
  assign stat.data_nonzero = (word_eff != '0);
  assign stat.scan_last = (word_inc >= limit);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word[AW-1:0]] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[raddr[AW-1:0]];
      rd_ok <= valid[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[word[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= req.mode;
      rem <= req.free_index;
      word <= '0;
      base <= '0;
    end else if (cmd.div_step) begin
      rem <= rem - WordStep;
      word <= word + CW'(1);
    end else if (cmd.scan_adv) begin
      word <= word + CW'(1);
      base <= base + WordStep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      slot_capacity <= CapacityReset;
      words_in_use <= WordsReset;
    end else begin
      if (cmd.cnt_dec && used_count != '0) begin
        used_count <= used_count - CountW'(1);
      end else if (cmd.wr_clr) begin
        used_count <= used_count + CountW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOT_CAPACITY: slot_capacity <= cfg_data;
          REG_WORDS_IN_USE:  words_in_use <= cfg_data[WordsW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status <= cmd.emit_status;
      rsp.slot_index <= cmd.wr_clr ? (base + IndexW'(lsb)) : '0;
    end
  end

endmodule
